// ===== rtl/npwr_pkg.sv =====
package npwr_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_ATOMS  = 1024;
  localparam int unsigned DEF_COORD_BITS = 16;

  // Fixed field and register widths.
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned TOL_W     = 16;
  localparam int unsigned CNT_CFG_W = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  // Each coordinate difference is clamped to this magnitude before squaring.
  localparam int unsigned DIFF_CLAMP = 65536;
  localparam int unsigned CLAMP_W    = 17;
  localparam int unsigned SQ_W       = 2 * CLAMP_W - 1;
  localparam int unsigned DIST_W     = 36;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT = 1'd1;

  // Opcodes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

endpackage

// ===== rtl/npwr_ram.sv =====
module npwr_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/npwr_dist.sv =====
module npwr_dist
  import npwr_pkg::*;
#(
  parameter int unsigned MAX_ATOMS  = DEF_MAX_ATOMS,
  parameter int unsigned COORD_BITS = DEF_COORD_BITS,
  localparam int unsigned AddrW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pt_valid_i,
  input  logic [AddrW-1:0]             pt_idx_i,
  input  logic [3*COORD_BITS-1:0]      pt_data_i,
  input  logic signed [COORD_BITS-1:0] q_x_i,
  input  logic signed [COORD_BITS-1:0] q_y_i,
  input  logic signed [COORD_BITS-1:0] q_z_i,
  output logic                         dist_valid_o,
  output logic [AddrW-1:0]             dist_idx_o,
  output logic [DIST_W-1:0]            dist_o,
  output logic                         busy_o
);

  localparam int unsigned DiffW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] pt_c [3];
  logic signed [COORD_BITS-1:0] q_c  [3];
  logic [CLAMP_W-1:0] mag_d [3];
  logic [CLAMP_W-1:0] mag_q [3];
  logic [SQ_W-1:0]    sq_q  [3];
  logic               va_q, vb_q;
  logic [AddrW-1:0]   idxa_q, idxb_q;

  assign pt_c[0] = pt_data_i[COORD_BITS-1:0];
  assign pt_c[1] = pt_data_i[2*COORD_BITS-1:COORD_BITS];
  assign pt_c[2] = pt_data_i[3*COORD_BITS-1:2*COORD_BITS];
  assign q_c[0]  = q_x_i;
  assign q_c[1]  = q_y_i;
  assign q_c[2]  = q_z_i;

  // Stage A: absolute difference per axis, clamped to the fixed limit.
  always_comb begin
    logic signed [DiffW-1:0] diff;
    logic [DiffW-1:0]        mag;
    for (int k = 0; k < 3; k++) begin
      diff = DiffW'(pt_c[k]) - DiffW'(q_c[k]);
      mag  = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
      if (64'(mag) > 64'(DIFF_CLAMP)) begin
        mag_d[k] = CLAMP_W'(DIFF_CLAMP);
      end else begin
        mag_d[k] = CLAMP_W'(mag);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= pt_valid_i;
      vb_q <= va_q;
    end
  end

  // Stage B: one multiplier per axis.
  always_ff @(posedge clk_i) begin
    idxa_q <= pt_idx_i;
    idxb_q <= idxa_q;
    for (int k = 0; k < 3; k++) begin
      mag_q[k] <= mag_d[k];
      sq_q[k]  <= SQ_W'(mag_q[k] * mag_q[k]);
    end
  end

  assign dist_o       = DIST_W'(sq_q[0]) + DIST_W'(sq_q[1]) + DIST_W'(sq_q[2]);
  assign dist_valid_o = vb_q;
  assign dist_idx_o   = idxb_q;
  assign busy_o       = va_q | vb_q;

endmodule

// ===== rtl/nearest_point_within_radius.sv =====
// Nearest stored point within a radius. A load request (opcode 0) writes one
// point into the store. A query request (opcode 1) walks entries 0 to
// atom_count-1 (limited to MAX_ATOMS), one store read per cycle, and returns
// the index of the closest entry whose squared distance is at or below
// tolerance squared, the later index winning a tie; a query that finds
// nothing returns no result. A query occupies the block while it reads each
// entry in turn on the single read port of the point store, drains the read,
// square and compare stages, closes the scan and hands the result to the
// output register. That last step waits for as long as an earlier result
// still sits unaccepted in the output register; the next request is taken
// once the result is handed over. Configuration is to be written only while
// the block is idle; the block itself does not enforce it.
module nearest_point_within_radius
  import npwr_pkg::*;
#(
  parameter int unsigned MAX_ATOMS  = DEF_MAX_ATOMS,
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DAT_W-1:0]         cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [SLOT_W-1:0]            slot_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [INDEX_W-1:0]           match_index_o
);

  localparam int unsigned AddrW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ATOMS + 1);
  localparam int unsigned PtW   = 3 * COORD_BITS;

  state_e state_d, state_q;

  logic [TOL_W-1:0]             tolerance_q;
  logic [CNT_CFG_W-1:0]         atom_count_q;
  logic [CntW-1:0]              count_q, count_d;
  logic [CntW-1:0]              rd_idx_q;
  logic signed [COORD_BITS-1:0] qx_q, qy_q, qz_q;
  logic [DIST_W-1:0]            best_q;
  logic [AddrW-1:0]             best_idx_q;
  logic                         found_q;
  logic                         v1_q;
  logic [AddrW-1:0]             idx1_q;
  logic                         out_valid_q;
  logic [INDEX_W-1:0]           match_q;

  logic                  in_acc, load_we, query_go, issuing, scan_done, out_load;
  logic [PtW-1:0]        rdata;
  logic                  dist_valid, dist_busy, better;
  logic [AddrW-1:0]      dist_idx;
  logic [DIST_W-1:0]     cand_dist;
  logic [2*TOL_W-1:0]    tol_sq;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign load_we     = in_acc && (opcode_i == OP_LOAD) && (32'(slot_i) < MAX_ATOMS);
  assign query_go    = in_acc && (opcode_i == OP_QUERY);
  assign issuing     = (state_q == ST_SCAN) && (rd_idx_q < count_q);
  assign scan_done   = (state_q == ST_SCAN) && !issuing && !v1_q && !dist_busy;
  assign out_load    = (state_q == ST_FINISH) && found_q && (!out_valid_q || out_ready_i);
  assign tol_sq      = tolerance_q * tolerance_q;
  assign better      = dist_valid && (cand_dist <= best_q);

  always_comb begin
    if (32'(atom_count_q) > MAX_ATOMS) begin
      count_d = CntW'(MAX_ATOMS);
    end else begin
      count_d = CntW'(atom_count_q);
    end
  end

  npwr_ram #(
    .Width(PtW),
    .Depth(MAX_ATOMS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(AddrW'(slot_i)),
    .wdata_i({pos_z_i, pos_y_i, pos_x_i}),
    .re_i   (issuing),
    .raddr_i(rd_idx_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  npwr_dist #(
    .MAX_ATOMS (MAX_ATOMS),
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_valid_i  (v1_q),
    .pt_idx_i    (idx1_q),
    .pt_data_i   (rdata),
    .q_x_i       (qx_q),
    .q_y_i       (qy_q),
    .q_z_i       (qz_q),
    .dist_valid_o(dist_valid),
    .dist_idx_o  (dist_idx),
    .dist_o      (cand_dist),
    .busy_o      (dist_busy)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (query_go) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!found_q || out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tolerance_q  <= '0;
      atom_count_q <= '0;
      count_q      <= '0;
      rd_idx_q     <= '0;
      best_q       <= '0;
      best_idx_q   <= '0;
      found_q      <= 1'b0;
      v1_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_TOLERANCE) begin
          tolerance_q <= cfg_data_i;
        end else if (cfg_index_i == REG_ATOM_COUNT) begin
          atom_count_q <= cfg_data_i[CNT_CFG_W-1:0];
        end
      end
      v1_q <= issuing;
      if (query_go) begin
        count_q    <= count_d;
        rd_idx_q   <= '0;
        best_q     <= DIST_W'(tol_sq);
        best_idx_q <= '0;
        found_q    <= 1'b0;
      end else begin
        if (issuing) begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
        // Entries arrive in index order, so <= lets the later index win a tie.
        if (better) begin
          best_q     <= cand_dist;
          best_idx_q <= dist_idx;
          found_q    <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issuing) begin
      idx1_q <= rd_idx_q[AddrW-1:0];
    end
    if (query_go) begin
      qx_q <= pos_x_i;
      qy_q <= pos_y_i;
      qz_q <= pos_z_i;
    end
    if (out_load) begin
      match_q <= INDEX_W'(best_idx_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_index_o = match_q;

  // The store is never read beyond the searched range.
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issuing |-> (rd_idx_q < count_q))
    else $error("store read beyond atom count");

  // The scan pipeline is empty whenever a new request can be taken.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!v1_q && !dist_busy))
    else $error("request taken while scan pipeline busy");

  // A delivered result lies inside the searched range.
  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (CntW'(best_idx_q) < count_q))
    else $error("result index outside searched range");

  // A result is only produced when a scan has finished.
  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result produced outside finish state");

endmodule

// ===== verif/tb_nearest_point_within_radius.sv =====
module tb_nearest_point_within_radius;
  import npwr_pkg::*;

  localparam int COORD_W = DEF_COORD_BITS;
  localparam int ATOMS   = DEF_MAX_ATOMS;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [CFG_IDX_W-1:0]       reg_idx;
    logic [CFG_DAT_W-1:0]       reg_val;
    logic                       op;
    logic [SLOT_W-1:0]          slot;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic                       known;
    logic                       known_hit;
    logic [INDEX_W-1:0]         known_idx;
  } stim_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DAT_W-1:0]       cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       opcode_i = OP_LOAD;
  logic [SLOT_W-1:0]          slot_i = '0;
  logic signed [COORD_W-1:0]  pos_x_i = '0;
  logic signed [COORD_W-1:0]  pos_y_i = '0;
  logic signed [COORD_W-1:0]  pos_z_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [INDEX_W-1:0]         match_index_o;

  // Shadow of the block: configuration and the point store.
  logic [TOL_W-1:0]           radius_q88 = '0;
  logic [CNT_CFG_W-1:0]       search_count = '0;
  logic signed [COORD_W-1:0]  pts_x [ATOMS];
  logic signed [COORD_W-1:0]  pts_y [ATOMS];
  logic signed [COORD_W-1:0]  pts_z [ATOMS];
  bit                         pt_loaded [ATOMS];

  logic [INDEX_W-1:0]         pending_matches [$];
  int                         error_count = 0;
  int                         items_sent = 0;
  int                         send_gap_pct = 8;
  int                         recv_stall_pct = 47;

  nearest_point_within_radius u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .slot_i        (slot_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .match_index_o (match_index_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(12 * 1_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic longint sq_gap(input logic signed [COORD_W-1:0] a,
                                    input logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    if (d > longint'(DIFF_CLAMP)) d = longint'(DIFF_CLAMP);
    return d * d;
  endfunction

  function automatic int active_span();
    return (search_count > ATOMS) ? ATOMS : int'(search_count);
  endfunction

  // Later entries win ties because the bound tightens with <=.
  function automatic void nearest_within_radius(input logic signed [COORD_W-1:0] qx,
                                                input logic signed [COORD_W-1:0] qy,
                                                input logic signed [COORD_W-1:0] qz,
                                                output bit hit,
                                                output logic [INDEX_W-1:0] idx);
    longint bound;
    longint sq_sum;
    hit = 1'b0;
    idx = '0;
    bound = longint'(radius_q88) * longint'(radius_q88);
    for (int i = 0; i < active_span(); i++) begin
      sq_sum = sq_gap(pts_x[i], qx) + sq_gap(pts_y[i], qy) + sq_gap(pts_z[i], qz);
      if (sq_sum <= bound) begin
        bound = sq_sum;
        idx = INDEX_W'(i);
        hit = 1'b1;
      end
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(input bit close);
    int v;
    if (close) v = int'($urandom_range(255)) - 128;
    else v = int'($urandom_range(65535)) - 32768;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] nudge(input logic signed [COORD_W-1:0] c,
                                                      input int reach);
    int v;
    v = int'(c) + int'($urandom_range(2 * reach)) - reach;
    return v[COORD_W-1:0];
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = value[CFG_DAT_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic op, input int slot,
                                         input int x, input int y, input int z);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.op = op;
    r.slot = slot[SLOT_W-1:0];
    r.x = x[COORD_W-1:0];
    r.y = y[COORD_W-1:0];
    r.z = z[COORD_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t known_row(input int x, input int y, input int z,
                                          input bit hit, input int idx);
    stim_row_t r;
    r = item_row(OP_QUERY, 0, x, y, z);
    r.known = 1'b1;
    r.known_hit = hit;
    r.known_idx = idx[INDEX_W-1:0];
    return r;
  endfunction

  // Presents one request and updates the shadow once it is taken.
  task automatic send_request(input logic op, input logic [SLOT_W-1:0] slot,
                              input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic signed [COORD_W-1:0] z,
                              input bit known, input bit known_hit,
                              input logic [INDEX_W-1:0] known_idx);
    int gap;
    bit hit;
    logic [INDEX_W-1:0] idx;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    slot_i <= slot;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (op == OP_LOAD) begin
      pts_x[slot] = x;
      pts_y[slot] = y;
      pts_z[slot] = z;
      pt_loaded[slot] = 1'b1;
    end else begin
      if (known) begin
        hit = known_hit;
        idx = known_idx;
      end else begin
        nearest_within_radius(x, y, z, hit, idx);
      end
      if (hit) pending_matches = {pending_matches, idx};
    end
  endtask

  // A query that finds nothing leaves no result to wait for, so the block
  // gets a full scan's worth of cycles after the last result.
  task automatic settle_block();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_matches.size() != 0 && waited < 5000 + 4 * active_span()) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_matches.size() != 0) begin
      flag_error($sformatf("%0d match results never arrived", pending_matches.size()));
      pending_matches.delete();
    end
    repeat (active_span() + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CFG_DAT_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_TOLERANCE) radius_q88 = value[TOL_W-1:0];
    else search_count = value[CNT_CFG_W-1:0];
  endtask

  // Now and then a point repeats its neighbor so that ties come up.
  task automatic load_point(input int slot, input bit close);
    logic signed [COORD_W-1:0] x, y, z;
    if (slot > 0 && pt_loaded[slot-1] && $urandom_range(9) == 0) begin
      x = pts_x[slot-1];
      y = pts_y[slot-1];
      z = pts_z[slot-1];
    end else begin
      x = pick_coord(close);
      y = pick_coord(close);
      z = pick_coord(close);
    end
    send_request(OP_LOAD, slot[SLOT_W-1:0], x, y, z, 1'b0, 1'b0, '0);
  endtask

  task automatic query_near(input int span);
    int j;
    int reach;
    j = $urandom_range(span - 1);
    reach = ($urandom_range(3) == 0) ? int'(radius_q88) : int'(radius_q88) / 2;
    send_request(OP_QUERY, SLOT_W'($urandom), nudge(pts_x[j], reach),
                 nudge(pts_y[j], reach), nudge(pts_z[j], reach), 1'b0, 1'b0, '0);
  endtask

  task automatic query_anywhere();
    send_request(OP_QUERY, SLOT_W'($urandom), pick_coord(1'b0), pick_coord(1'b0),
                 pick_coord(1'b0), 1'b0, 1'b0, '0);
  endtask

  // One scene: new radius and count, a fresh fill of the searched entries,
  // then queries mixed with overwrites.
  task automatic scene_round();
    int tol;
    int n;
    int pick;
    bit close;
    close = $urandom_range(1);
    case ($urandom_range(5))
      0: tol = 0;
      1: tol = 65535;
      2: tol = $urandom_range(1, 64);
      3, 4: tol = $urandom_range(65, 2000);
      default: tol = $urandom_range(65535);
    endcase
    pick = $urandom_range(9);
    if (pick == 0) n = 0;
    else if (pick < 7) n = $urandom_range(1, 16);
    else n = $urandom_range(17, 64);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_ATOM_COUNT, n);
    for (int i = 0; i < n; i++) load_point(i, close);
    repeat ((n == 0) ? 4 : $urandom_range(8, 24)) begin
      pick = $urandom_range(99);
      if (pick < 55 && n > 0) begin
        query_near(n);
      end else if (pick < 70 || n == 0) begin
        query_anywhere();
      end else begin
        load_point((n > 0 && $urandom_range(3) != 0) ? $urandom_range(n - 1)
                                                     : $urandom_range(ATOMS - 1), close);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_matches.size() == 0) begin
          flag_error($sformatf("unexpected result, match_index %0d", match_index_o));
        end else begin
          if (match_index_o !== pending_matches[0]) begin
            flag_error($sformatf("match_index: expected %0d, got %0d",
                                 pending_matches[0], match_index_o));
          end
          void'(pending_matches.pop_front());
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    stim_row_t directed_rows [$];
    int mode_start;

    // A query right after reset searches nothing.
    directed_rows = {directed_rows, known_row(0, 0, 0, 1'b0, 0)};
    directed_rows = {directed_rows, item_row(OP_LOAD, 0, 0, 0, 0)};
    directed_rows = {directed_rows, item_row(OP_LOAD, 1, 32767, 32767, 32767)};
    directed_rows = {directed_rows, item_row(OP_LOAD, 2, -32768, -32768, -32768)};
    directed_rows = {directed_rows, item_row(OP_LOAD, 3, 0, 0, 0)};
    directed_rows = {directed_rows, item_row(OP_LOAD, 1023, 4660, -22136, 13398)};
    directed_rows = {directed_rows, cfg_row(REG_ATOM_COUNT, 4)};
    // Zero radius: only exact hits count, and the later duplicate wins.
    directed_rows = {directed_rows, known_row(0, 0, 0, 1'b1, 3)};
    directed_rows = {directed_rows, known_row(1, 0, 0, 1'b0, 0)};
    directed_rows = {directed_rows, cfg_row(REG_TOLERANCE, 65535)};
    directed_rows = {directed_rows, item_row(OP_QUERY, 1023, 32767, -32768, 0)};
    directed_rows = {directed_rows, item_row(OP_QUERY, 0, -32768, -32768, -32768)};
    directed_rows = {directed_rows, item_row(OP_QUERY, 682, 32767, 32767, 32767)};
    directed_rows = {directed_rows, cfg_row(REG_TOLERANCE, 1)};
    // Distance exactly at the radius still matches.
    directed_rows = {directed_rows, known_row(1, 0, 0, 1'b1, 3)};
    directed_rows = {directed_rows, known_row(1, 1, 0, 1'b0, 0)};
    directed_rows = {directed_rows, cfg_row(REG_TOLERANCE, 300)};
    directed_rows = {directed_rows, item_row(OP_QUERY, 341, 100, -200, 50)};
    directed_rows = {directed_rows, cfg_row(REG_ATOM_COUNT, 0)};
    directed_rows = {directed_rows, known_row(0, 0, 0, 1'b0, 0)};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
      end else begin
        send_request(directed_rows[k].op, directed_rows[k].slot, directed_rows[k].x,
                     directed_rows[k].y, directed_rows[k].z, directed_rows[k].known,
                     directed_rows[k].known_hit, directed_rows[k].known_idx);
      end
    end

    for (int m = 0; m < 3; m++) begin
      send_gap_pct = (m == 0) ? 8 : (m == 1) ? 47 : 0;
      recv_stall_pct = (m == 0) ? 47 : (m == 1) ? 8 : 0;
      mode_start = items_sent;
      while (items_sent - mode_start < 135) scene_round();
    end

    settle_block();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
